### sv/csu_pkg.sv
// csu_pkg: shared types and codes for the counting semaphore unit
// request/response words, controller command and status structs
// no dependencies
package csu_pkg;

	localparam logic [2:0] OP_INIT    = 3'd0;
	localparam logic [2:0] OP_WAIT    = 3'd1;
	localparam logic [2:0] OP_SIGNAL  = 3'd2;
	localparam logic [2:0] OP_DESTROY = 3'd3;
	localparam logic [2:0] OP_BLOCK   = 3'd4;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	localparam logic signed [15:0] COUNT_MAX = 16'sh7fff;
	localparam logic signed [15:0] COUNT_MIN = 16'sh8000;

	typedef struct packed {
		logic [2:0]         op;
		logic [3:0]         sem_id;
		logic [7:0]         caller;
		logic signed [15:0] init_value;
	} req_t;

	typedef struct packed {
		logic       caller_suspended;
		logic       wake_valid;
		logic [7:0] woken_process;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic finish;
	} csu_cmd_t;

	typedef struct packed {
		logic rsp_full;
	} csu_sts_t;

endpackage

### sv/csu_ram.sv
// csu_ram: generic single write port, single read port RAM
// read data registered, no reset on contents; no dependencies
module csu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/csu_ctrl.sv
// csu_ctrl: request sequencer for the counting semaphore unit
// issues capture, update and finish commands; uses csu_pkg
module csu_ctrl import csu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     rsp_stall,
	input  csu_sts_t sts,
	output csu_cmd_t cmd,
	output logic     ready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_free;
	logic       accept;

	always_comb begin
		out_free    = !sts.rsp_full || !rsp_stall;
		ready       = (state_q == ST_IDLE) || ((state_q == ST_DONE) && out_free);
		accept      = req_valid && ready;
		cmd.capture = accept;
		cmd.update  = (state_q == ST_READ);
		cmd.finish  = (state_q == ST_DONE) && out_free;
		state_d     = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = accept ? ST_READ : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### sv/csu_dp.sv
// csu_dp: datapath of the counting semaphore unit
// semaphore record RAM, waiter RAM, update logic, response register
// uses csu_pkg and csu_ram
module csu_dp import csu_pkg::*; #(
	parameter int NUM_SEMAPHORES = 16,
	parameter int QUEUE_DEPTH    = 16,
	parameter int PROC_BITS      = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  csu_cmd_t cmd,
	output csu_sts_t sts,
	input  req_t     req,
	input  logic     rsp_stall,
	output logic     rsp_valid,
	output rsp_t     rsp
);

	localparam int SEM_W  = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
	localparam int QAW    = $clog2(QUEUE_DEPTH);
	localparam int QFW    = $clog2(QUEUE_DEPTH + 1);
	localparam int WDEPTH = NUM_SEMAPHORES * QUEUE_DEPTH;
	localparam int WAW    = $clog2(WDEPTH);

	typedef struct packed {
		logic signed [15:0] count;
		logic [QAW-1:0]     head;
		logic [QAW-1:0]     tail;
		logic [QFW-1:0]     fill;
	} sem_entry_t;

	localparam int ENTRY_W = $bits(sem_entry_t);

	function automatic logic [QAW-1:0] next_slot(input logic [QAW-1:0] i);
		return (i == QAW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	logic [2:0]               op_q;
	logic [SEM_W-1:0]         sem_q;
	logic                     hit_q;
	logic [PROC_BITS-1:0]     caller_q;
	logic signed [15:0]       init_q;
	logic [NUM_SEMAPHORES-1:0] vld_q;
	logic                     vld_rd_q;
	logic                     req_hit;
	logic [SEM_W-1:0]         req_sem;
	logic [ENTRY_W-1:0]       ram_rdata;
	sem_entry_t               cur;
	sem_entry_t               nxt;
	logic signed [15:0]       c_dec;
	logic signed [15:0]       c_inc;
	logic                     sem_we;
	logic                     w_we;
	logic                     w_re;
	logic [QAW-1:0]           w_slot;
	logic [WAW-1:0]           w_addr;
	logic [PROC_BITS-1:0]     w_rdata;
	logic                     susp_d;
	logic                     wake_d;
	logic [1:0]               stat_d;
	logic                     susp_q;
	logic                     wake_q;
	logic [1:0]               stat_q;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;

	assign req_hit = ({28'd0, req.sem_id} < 32'(NUM_SEMAPHORES));
	assign req_sem = SEM_W'(req.sem_id);
	assign cur     = vld_rd_q ? sem_entry_t'(ram_rdata) : '0;
	assign c_dec   = (cur.count == COUNT_MIN) ? cur.count : cur.count - 16'sd1;
	assign c_inc   = (cur.count == COUNT_MAX) ? cur.count : cur.count + 16'sd1;
	assign w_addr  = WAW'(sem_q * QUEUE_DEPTH) + WAW'(w_slot);

	always_comb begin
		nxt    = cur;
		sem_we = 1'b0;
		w_we   = 1'b0;
		w_re   = 1'b0;
		w_slot = cur.tail;
		susp_d = 1'b0;
		wake_d = 1'b0;
		stat_d = STAT_OK;
		if (cmd.update && hit_q) begin
			case (op_q)
				OP_INIT: begin
					nxt.count = init_q;
					nxt.head  = '0;
					nxt.tail  = '0;
					nxt.fill  = '0;
					sem_we    = 1'b1;
				end
				OP_WAIT: begin
					if (c_dec[15]) begin
						if (cur.fill == QFW'(QUEUE_DEPTH)) begin
							stat_d = STAT_FULL;
						end else begin
							w_we      = 1'b1;
							w_slot    = cur.tail;
							nxt.tail  = next_slot(cur.tail);
							nxt.fill  = cur.fill + 1'b1;
							nxt.count = c_dec;
							susp_d    = 1'b1;
							sem_we    = 1'b1;
						end
					end else begin
						nxt.count = c_dec;
						sem_we    = 1'b1;
					end
				end
				OP_SIGNAL, OP_BLOCK: begin
					nxt.count = c_inc;
					sem_we    = 1'b1;
					susp_d    = (op_q == OP_BLOCK);
					if (c_inc[15] || (c_inc == 16'sd0)) begin
						if (cur.fill != '0) begin
							w_re     = 1'b1;
							w_slot   = cur.head;
							wake_d   = 1'b1;
							nxt.head = next_slot(cur.head);
							nxt.fill = cur.fill - 1'b1;
						end else begin
							stat_d = STAT_EMPTY;
						end
					end
				end
				OP_DESTROY: begin
					nxt.count = '0;
					nxt.head  = '0;
					nxt.tail  = '0;
					nxt.fill  = '0;
					sem_we    = 1'b1;
				end
				default: begin
					sem_we = 1'b0;
				end
			endcase
		end
	end

	csu_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_SEMAPHORES)
	) u_sem_ram (
		.clk  (clk),
		.we   (sem_we),
		.waddr(sem_q),
		.wdata(ENTRY_W'(nxt)),
		.re   (cmd.capture),
		.raddr(req_sem),
		.rdata(ram_rdata)
	);

	csu_ram #(
		.WIDTH(PROC_BITS),
		.DEPTH(WDEPTH)
	) u_waiter_ram (
		.clk  (clk),
		.we   (w_we),
		.waddr(w_addr),
		.wdata(caller_q),
		.re   (w_re),
		.raddr(w_addr),
		.rdata(w_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= req.op;
			sem_q    <= req_sem;
			hit_q    <= req_hit;
			caller_q <= PROC_BITS'(req.caller);
			init_q   <= req.init_value;
			vld_rd_q <= req_hit ? vld_q[req_sem] : 1'b0;
		end
		if (cmd.update) begin
			susp_q <= susp_d;
			wake_q <= wake_d;
			stat_q <= stat_d;
		end
		if (cmd.finish) begin
			rsp_q.caller_suspended <= susp_q;
			rsp_q.wake_valid       <= wake_q;
			rsp_q.woken_process    <= wake_q ? 8'(w_rdata) : 8'd0;
			rsp_q.status           <= stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (sem_we) begin
				vld_q[sem_q] <= 1'b1;
			end
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign sts.rsp_full = rsp_valid_q;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;

endmodule

### sv/counting_semaphore_unit.sv
// Bank of NUM_SEMAPHORES counting semaphores, each with a signed 16-bit count and a FIFO of
// up to QUEUE_DEPTH waiting process numbers. A request is read from the semaphore's record
// RAM in the accept cycle, updated (with at most one waiter RAM access) in the next cycle,
// and its response word is then loaded into the output register, raising rsp_valid, once
// the output is free. A new request can be taken on the edge that loads the previous
// response; none is taken while one is in its update step, because of the read-update loop
// on the record RAM. A stalled response holds the block after the update step. Records
// read as zero until first written, so no clearing pass follows reset.
// Depends on csu_pkg, csu_ctrl, csu_dp, csu_ram.
module counting_semaphore_unit import csu_pkg::*; #(
	parameter int NUM_SEMAPHORES = 16,
	parameter int QUEUE_DEPTH    = 16,
	parameter int PROC_BITS      = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	csu_cmd_t cmd;
	csu_sts_t sts;
	logic     ready;

	csu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.cmd      (cmd),
		.ready    (ready)
	);

	csu_dp #(
		.NUM_SEMAPHORES(NUM_SEMAPHORES),
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.PROC_BITS     (PROC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req      (req),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

	assign req_stall = !ready;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while previous one still in update");

	a_rsp_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && !req_stall, 3))
		else $error("response word appeared without a matching request");

	a_no_wake_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.wake_valid) |-> (rsp.woken_process == 8'd0))
		else $error("woken process number set without a wakeup");
`endif

endmodule
